/* rtl/pfd_pkg.sv */
// pfd_pkg: shared types, constants, the header byte function and the conversion function of the pressure frame decoder
// used by pfd_front, pfd_queue, pfd_back and pressure_frame_decoder; no dependencies
package pfd_pkg;

    localparam int NCH       = 3;
    localparam int SHIFT_LEN = 9;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] HDR_A = 8'h41;
    localparam logic [7:0] HDR_B = 8'h42;
    localparam logic [7:0] HDR_C = 8'h43;

    localparam logic [1:0] HDR_LAST  = 2'd2;
    localparam logic [3:0] PAY_LAST  = 4'd10;

    localparam int CH_METHANE  = 0;
    localparam int CH_OXIDIZER = 1;
    localparam int CH_HELIUM   = 2;

    localparam logic [31:0] GAIN_RESET   = 32'h0001_0000;
    localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;
    localparam logic [31:0] SAT_MAX      = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN      = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_METHANE_GAIN    = 3'd0,
        REG_METHANE_OFFSET  = 3'd1,
        REG_OXIDIZER_GAIN   = 3'd2,
        REG_OXIDIZER_OFFSET = 3'd3,
        REG_HELIUM_GAIN     = 3'd4,
        REG_HELIUM_OFFSET   = 3'd5
    } pfd_reg_e;

    typedef struct packed {
        logic [31:0]           stamp;
        logic [NCH-1:0][15:0]  raw;
    } pfd_frame_t;

    typedef struct packed {
        logic [31:0]           stamp;
        logic [NCH-1:0][31:0]  pressure;
    } pfd_result_t;

    typedef struct packed {
        logic [31:0] gain;
        logic [31:0] offset;
    } pfd_coef_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } pfd_qstat_t;

    function automatic logic [7:0] pfd_hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = HDR_A;
            2'd1:    b = HDR_B;
            default: b = HDR_C;
        endcase
        return b;
    endfunction

    // product minus signed offset, clamped to signed 32 bits
    function automatic logic [31:0] pfd_convert(input logic [47:0] prod,
                                                input logic [31:0] offset);
        logic signed [49:0] r;
        logic [31:0]        res;
        r = $signed({2'b00, prod}) - $signed({{18{offset[31]}}, offset});
        if (r[49:31] == {19{1'b0}} || r[49:31] == {19{1'b1}})
        begin
            res = r[31:0];
        end
        else if (r[49])
        begin
            res = SAT_MIN;
        end
        else
        begin
            res = SAT_MAX;
        end
        return res;
    endfunction

endpackage

/* rtl/pressure_frame_decoder.sv */
// pressure_frame_decoder: top level with configuration registers and assertions
// depends on pfd_pkg, pfd_front, pfd_queue and pfd_back
//
// Serial bytes enter one per cycle on rx_byte while in_stall is low; the decoder hunts for the
// header "ABC", then collects an 11-byte payload and emits one result per frame: the
// little-endian timestamp from payload bytes two to five and three pressures, each raw count
// times gain minus offset in signed Q16.16, clamped to 32 bits. After the last payload byte is
// accepted, the frame passes through the two-entry frame queue and the multiply stage, whose
// product is offset and clamped straight into the output register. Input stall rises only
// while that queue is full, which takes a long output stall with the output register, the
// multiply stage and both queue entries all holding frames. Gain and offset registers are
// written through cfg_we, cfg_index and cfg_data while no frame is in flight; the user must
// keep to this, as the block itself leaves it unenforced. Indexes six and seven are ignored.
module pressure_frame_decoder
    import pfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        frame_time,
    output logic signed [31:0] methane_pressure,
    output logic signed [31:0] oxidizer_pressure,
    output logic signed [31:0] helium_pressure,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    pfd_coef_t   coef_reg [NCH];
    pfd_frame_t  front_frame, queue_frame;
    pfd_qstat_t  qstat;
    pfd_result_t result;
    logic        push, pop, queue_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                coef_reg[i].gain   <= GAIN_RESET;
                coef_reg[i].offset <= OFFSET_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_METHANE_GAIN:    coef_reg[CH_METHANE].gain    <= cfg_data;
                REG_METHANE_OFFSET:  coef_reg[CH_METHANE].offset  <= cfg_data;
                REG_OXIDIZER_GAIN:   coef_reg[CH_OXIDIZER].gain   <= cfg_data;
                REG_OXIDIZER_OFFSET: coef_reg[CH_OXIDIZER].offset <= cfg_data;
                REG_HELIUM_GAIN:     coef_reg[CH_HELIUM].gain     <= cfg_data;
                REG_HELIUM_OFFSET:   coef_reg[CH_HELIUM].offset   <= cfg_data;
                default:             ;
            endcase
        end
    end

    pfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .qstat    (qstat),
        .push     (push),
        .frame    (front_frame)
    );

    pfd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (front_frame),
        .pop    (pop),
        .rvalid (queue_valid),
        .rdata  (queue_frame),
        .qstat  (qstat)
    );

    pfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (queue_valid),
        .frame       (queue_frame),
        .pop         (pop),
        .coef        (coef_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    assign frame_time        = result.stamp;
    assign methane_pressure  = $signed(result.pressure[CH_METHANE]);
    assign oxidizer_pressure = $signed(result.pressure[CH_OXIDIZER]);
    assign helium_pressure   = $signed(result.pressure[CH_HELIUM]);

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= QCNT_W'(QDEPTH))
        else $error("frame queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("frame pushed into a full queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> queue_valid)
        else $error("pushed frame missing from queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.count != '0)
        else $error("frame taken from an empty queue");

endmodule

/* rtl/pfd_front.sv */
// pfd_front: header hunt and payload collection, one byte per cycle while the frame queue is not full
// depends on pfd_pkg; pushes finished frames into pfd_queue
module pfd_front
    import pfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  pfd_qstat_t qstat,
    output logic       push,
    output pfd_frame_t frame
);

    logic [1:0] hm_reg, hm_next;
    logic       in_payload_reg, in_payload_next;
    logic [3:0] count_reg, count_next;
    logic [SHIFT_LEN-1:0][7:0] shift_reg, shift_next;

    logic       accept;
    logic [1:0] hm_cur;
    logic [3:0] cnt_cur;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;

    always_comb
    begin
        hm_next         = hm_reg;
        in_payload_next = in_payload_reg;
        count_next      = count_reg;
        shift_next      = shift_reg;
        push            = 1'b0;
        hm_cur          = (hm_reg > HDR_LAST) ? 2'd0 : hm_reg;
        cnt_cur         = (count_reg > PAY_LAST) ? 4'd0 : count_reg;
        if (accept)
        begin
            if (!in_payload_reg)
            begin
                if (rx_byte == pfd_hdr_byte(hm_cur))
                begin
                    if (hm_cur == HDR_LAST)
                    begin
                        hm_next         = 2'd0;
                        in_payload_next = 1'b1;
                        count_next      = 4'd0;
                    end
                    else
                    begin
                        hm_next = hm_cur + 2'd1;
                    end
                end
                else
                begin
                    hm_next = (rx_byte == HDR_A) ? 2'd1 : 2'd0;
                end
            end
            else
            begin
                shift_next = {shift_reg[SHIFT_LEN-2:0], rx_byte};
                if (cnt_cur == PAY_LAST)
                begin
                    push            = 1'b1;
                    in_payload_next = 1'b0;
                    count_next      = 4'd0;
                    hm_next         = 2'd0;
                end
                else
                begin
                    count_next = cnt_cur + 4'd1;
                end
            end
        end
    end

    // on the last byte the shift line holds payload bytes two to ten, newest first
    assign frame.stamp            = {shift_reg[5], shift_reg[6], shift_reg[7], shift_reg[8]};
    assign frame.raw[CH_METHANE]  = {shift_reg[3], shift_reg[4]};
    assign frame.raw[CH_OXIDIZER] = {shift_reg[1], shift_reg[2]};
    assign frame.raw[CH_HELIUM]   = {rx_byte, shift_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hm_reg         <= 2'd0;
            in_payload_reg <= 1'b0;
            count_reg      <= 4'd0;
        end
        else
        begin
            hm_reg         <= hm_next;
            in_payload_reg <= in_payload_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

/* rtl/pfd_queue.sv */
// pfd_queue: two-entry frame queue between front and back
// depends on pfd_pkg
module pfd_queue
    import pfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pfd_frame_t wdata,
    input  logic       pop,
    output logic       rvalid,
    output pfd_frame_t rdata,
    output pfd_qstat_t qstat
);

    pfd_frame_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.count = count_reg;
    assign rvalid      = (count_reg != '0);
    assign rdata       = mem_reg[rd_ptr_reg];
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && rvalid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/pfd_back.sv */
// pfd_back: two-stage conversion, multiply then offset and saturate into the output register
// depends on pfd_pkg; takes frames from pfd_queue
module pfd_back
    import pfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    input  pfd_frame_t  frame,
    output logic        pop,
    input  pfd_coef_t   coef [NCH],
    output logic        out_valid,
    input  logic        out_stall,
    output pfd_result_t result
);

    logic                 s1_valid_reg;
    logic [31:0]          s1_stamp_reg;
    logic [NCH-1:0][47:0] s1_prod_reg, s1_prod_next;
    logic                 out_valid_reg;
    pfd_result_t          result_reg, result_next;
    logic                 s1_load, s2_load;

    assign s2_load = !out_valid_reg || !out_stall;
    assign s1_load = !s1_valid_reg || s2_load;
    assign pop     = frame_valid && s1_load;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            s1_prod_next[i]         = 48'(frame.raw[i]) * 48'(coef[i].gain);
            result_next.pressure[i] = pfd_convert(s1_prod_reg[i], coef[i].offset);
        end
        result_next.stamp = s1_stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= frame_valid;
            end
            if (s2_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_stamp_reg <= frame.stamp;
            s1_prod_reg  <= s1_prod_next;
        end
        if (s2_load && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
